[rtl/clcd_pkg.sv]
// Package for the character LCD nibble write sequencer.
// Field widths, request codes, timing constants, the queued job type and
// the init command table. No dependencies.
`default_nettype none

package clcd_pkg;

   // Field widths
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 8;
   localparam int COLUMN_W = 6;
   localparam int NUMBER_W = 32;
   localparam int NIBBLE_W = 4;
   localparam int WAIT_W   = 6;

   // Integer display
   localparam int MAX_DIGITS = 10;
   localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

   // Bytes per request
   localparam int INIT_BYTES = 5;
   localparam int MAX_BYTES  = (MAX_DIGITS + 1 > INIT_BYTES) ? MAX_DIGITS + 1 : INIT_BYTES;
   localparam int BYTE_W     = $clog2(MAX_BYTES + 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request codes
   localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
   localparam logic [OP_W-1:0] OP_COMMAND = 3'd1;
   localparam logic [OP_W-1:0] OP_DATA    = 3'd2;
   localparam logic [OP_W-1:0] OP_TEXT    = 3'd3;
   localparam logic [OP_W-1:0] OP_SETPOS  = 3'd4;
   localparam logic [OP_W-1:0] OP_INTEGER = 3'd5;

   // Byte constants
   localparam logic [VALUE_W-1:0] POS_CMD   = 8'h80;
   localparam logic [VALUE_W-1:0] ROW1_BIT  = 8'h40;
   localparam logic [VALUE_W-1:0] CHAR_ZERO = 8'h30;

   // Hold times in ms
   localparam logic [WAIT_W-1:0] WAIT_NONE      = 6'd0;
   localparam logic [WAIT_W-1:0] WAIT_NIBBLE    = 6'd2;
   localparam logic [WAIT_W-1:0] WAIT_TEXT      = 6'd5;
   localparam logic [WAIT_W-1:0] WAIT_INIT_IDLE = 6'd40;

   // Divide by ten: q = (n * RECIP10) >> RECIP10_SHIFT, exact for 32-bit n
   localparam logic [2*NUMBER_W-1:0] RECIP10       = 64'h0000_0000_CCCC_CCCD;
   localparam int                    RECIP10_SHIFT = 35;

   // One request as the back end sees it
   typedef struct packed {
      logic                                is_init;
      logic                                has_pos;
      logic [VALUE_W-1:0]                  pos_addr;
      logic                                pay_rs;
      logic [WAIT_W-1:0]                   pay_trail;
      logic                                use_digits;
      logic [VALUE_W-1:0]                  value;
      logic [CNT_W-1:0]                    pay_count;
      logic [MAX_DIGITS-1:0][NIBBLE_W-1:0] digits;
   } clcd_job_type;

   // One pin event
   typedef struct packed {
      logic                reg_select;
      logic                read_write;
      logic [NIBBLE_W-1:0] data_nibble;
      logic                enable;
      logic [WAIT_W-1:0]   wait_ms;
      logic                last;
   } clcd_event_type;

   function automatic logic [VALUE_W-1:0] init_byte(input logic [2:0] idx);
      logic [VALUE_W-1:0] b;
      unique case (idx)
         3'd0:    b = 8'h02;   // 4-bit mode
         3'd1:    b = 8'h2C;   // two lines, 5x10 font
         3'd2:    b = 8'h0C;   // display on, cursor off
         3'd3:    b = 8'h01;   // clear
         3'd4:    b = 8'h06;   // entry mode, increment
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [WAIT_W-1:0] init_trail(input logic [2:0] idx);
      logic [WAIT_W-1:0] t;
      unique case (idx)
         3'd1, 3'd2: t = 6'd1;
         3'd3:       t = 6'd2;
         default:    t = WAIT_NONE;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

[rtl/clcd_if.sv]
// Handshake interfaces for the request and the pin event channels.
// Depends on clcd_pkg for field widths.
`default_nettype none

interface clcd_req_if;
   import clcd_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [VALUE_W-1:0]  value;
   logic                row;
   logic [COLUMN_W-1:0] column;
   logic [NUMBER_W-1:0] number;
   logic                starts_text;

   modport source (output valid, op, value, row, column, number, starts_text, input ready);
   modport sink   (input valid, op, value, row, column, number, starts_text, output ready);
endinterface

interface clcd_rsp_if;
   import clcd_pkg::*;
   logic                valid;
   logic                ready;
   logic                reg_select;
   logic                read_write;
   logic [NIBBLE_W-1:0] data_nibble;
   logic                enable;
   logic [WAIT_W-1:0]   wait_ms;
   logic                last;

   modport source (output valid, reg_select, read_write, data_nibble, enable, wait_ms, last,
                   input ready);
   modport sink   (input valid, reg_select, read_write, data_nibble, enable, wait_ms, last,
                   output ready);
endinterface

`default_nettype wire

[rtl/clcd_front.sv]
// Front end: accepts requests, classifies them into jobs and converts integers
// to decimal digits. Depends on clcd_pkg and clcd_req_if.
`default_nettype none

module clcd_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   clcd_req_if.sink                    req_ch,
   input  wire logic                   queue_full,
   output      logic                   push_valid,
   output      clcd_pkg::clcd_job_type push_job
);
   import clcd_pkg::*;

   localparam logic F_TAKE = 1'b0;
   localparam logic F_CONV = 1'b1;

   logic                 state_ff, state_in;
   clcd_job_type         job_ff, job_in, new_job;
   logic [NUMBER_W-1:0]  num_ff, num_in;
   logic [DIG_IDX_W-1:0] k_ff, k_in;
   logic                 op_known;
   logic                 accept;
   logic [VALUE_W-1:0]   addr;
   logic [2*NUMBER_W-1:0] product;
   logic [NUMBER_W-1:0]  quot;
   logic [NUMBER_W-1:0]  quot_x10;
   logic [NUMBER_W-1:0]  remainder;

   assign req_ch.ready = (state_ff == F_TAKE) && !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign addr = POS_CMD | (req_ch.row ? ROW1_BIT : 8'h00)
                         | {{(VALUE_W-COLUMN_W){1'b0}}, req_ch.column};

   // Classify the incoming request
   always_comb begin
      new_job            = '0;
      new_job.pos_addr   = addr;
      new_job.value      = req_ch.value;
      new_job.digits     = job_ff.digits;
      op_known           = 1'b1;
      unique case (req_ch.op)
         OP_INIT: begin
            new_job.is_init = 1'b1;
         end
         OP_COMMAND: begin
            new_job.pay_count = CNT_W'(1);
         end
         OP_DATA: begin
            new_job.pay_rs    = 1'b1;
            new_job.pay_count = CNT_W'(1);
         end
         OP_TEXT: begin
            new_job.has_pos   = req_ch.starts_text;
            new_job.pay_rs    = 1'b1;
            new_job.pay_trail = WAIT_TEXT;
            new_job.pay_count = CNT_W'(1);
         end
         OP_SETPOS: begin
            new_job.has_pos = 1'b1;
         end
         OP_INTEGER: begin
            new_job.has_pos    = 1'b1;
            new_job.pay_rs     = 1'b1;
            new_job.pay_trail  = WAIT_TEXT;
            new_job.use_digits = 1'b1;
         end
         default: begin
            op_known = 1'b0;
         end
      endcase
   end

   // One decimal digit per cycle
   assign product   = {{NUMBER_W{1'b0}}, num_ff} * RECIP10;
   assign quot      = NUMBER_W'(product >> RECIP10_SHIFT);
   assign quot_x10  = (quot << 3) + (quot << 1);
   assign remainder = num_ff - quot_x10;

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      num_in     = num_ff;
      k_in       = k_ff;
      push_valid = 1'b0;
      unique case (state_ff)
         F_TAKE: begin
            if (accept && op_known) begin
               if (req_ch.op == OP_INTEGER) begin
                  job_in   = new_job;
                  num_in   = req_ch.number;
                  k_in     = '0;
                  state_in = F_CONV;
               end else begin
                  job_in     = new_job;
                  push_valid = 1'b1;
               end
            end
         end
         F_CONV: begin
            job_in.digits[k_ff] = remainder[NIBBLE_W-1:0];
            job_in.pay_count    = CNT_W'(k_ff) + CNT_W'(1);
            num_in              = quot;
            k_in                = k_ff + DIG_IDX_W'(1);
            if ((quot == '0) || (k_ff == DIG_IDX_W'(MAX_DIGITS - 1))) begin
               push_valid = 1'b1;
               state_in   = F_TAKE;
            end
         end
         default: begin
            state_in = F_TAKE;
         end
      endcase
   end

   assign push_job = job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_TAKE;
      end else begin
         state_ff <= state_in;
      end
      job_ff <= job_in;
      num_ff <= num_in;
      k_ff   <= k_in;
   end

endmodule

`default_nettype wire

[rtl/clcd_queue.sv]
// Short job queue between the front and back ends.
// Depends on clcd_pkg for the job type and depth.
`default_nettype none

module clcd_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  clcd_pkg::clcd_job_type      push_job,
   output      logic                   full,
   output      logic                   pop_valid,
   output      clcd_pkg::clcd_job_type pop_job,
   input  wire logic                   pop_ready
);
   import clcd_pkg::*;

   clcd_job_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/clcd_back.sv]
// Back end: walks one job byte by byte and nibble by nibble and emits pin
// events through an output register. Depends on clcd_pkg and clcd_rsp_if.
`default_nettype none

module clcd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  clcd_pkg::clcd_job_type job,
   output      logic              job_pop,
   clcd_rsp_if.source             rsp_ch
);
   import clcd_pkg::*;

   localparam logic [1:0] B_WAIT  = 2'd0;
   localparam logic [1:0] B_IDLEV = 2'd1;
   localparam logic [1:0] B_BYTES = 2'd2;

   logic [1:0]          state_ff, state_in;
   clcd_job_type        job_ff, job_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [1:0]          nib_ff, nib_in;
   logic                pin_rs_ff, pin_rs_in;
   logic [NIBBLE_W-1:0] pin_nib_ff, pin_nib_in;
   logic                pin_e_ff, pin_e_in;
   logic                out_valid_ff, out_valid_in;
   clcd_event_type      out_ev_ff, out_ev_in;

   logic                advance;
   logic [BYTE_W-1:0]   total_bytes;
   logic [BYTE_W-1:0]   pay_pos;
   logic [CNT_W-1:0]    dig_sel;
   logic [VALUE_W-1:0]  cur_byte;
   logic                cur_rs;
   logic [WAIT_W-1:0]   cur_trail;
   logic                last_byte;
   clcd_event_type      ev;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign job_pop = (state_ff == B_WAIT) && job_valid;

   assign total_bytes = job_ff.is_init ? BYTE_W'(INIT_BYTES)
                      : BYTE_W'(job_ff.has_pos) + BYTE_W'(job_ff.pay_count);
   assign pay_pos     = byte_ff - BYTE_W'(job_ff.has_pos);
   assign dig_sel     = job_ff.pay_count - CNT_W'(1) - CNT_W'(pay_pos);
   assign last_byte   = (byte_ff == total_bytes - BYTE_W'(1));

   // Byte currently on its way out
   always_comb begin
      if (job_ff.is_init) begin
         cur_byte  = init_byte(byte_ff[2:0]);
         cur_rs    = 1'b0;
         cur_trail = init_trail(byte_ff[2:0]);
      end else if (job_ff.has_pos && (byte_ff == '0)) begin
         cur_byte  = job_ff.pos_addr;
         cur_rs    = 1'b0;
         cur_trail = WAIT_NONE;
      end else begin
         cur_byte  = job_ff.use_digits
                   ? CHAR_ZERO + {{(VALUE_W-NIBBLE_W){1'b0}},
                                  job_ff.digits[dig_sel[DIG_IDX_W-1:0]]}
                   : job_ff.value;
         cur_rs    = job_ff.pay_rs;
         cur_trail = job_ff.pay_trail;
      end
   end

   // Event for the present step
   always_comb begin
      ev = '0;
      if (state_ff == B_IDLEV) begin
         ev.reg_select  = pin_rs_ff;
         ev.data_nibble = pin_nib_ff;
         ev.enable      = pin_e_ff;
         ev.wait_ms     = WAIT_INIT_IDLE;
      end else begin
         ev.reg_select  = cur_rs;
         ev.data_nibble = nib_ff[1] ? cur_byte[NIBBLE_W-1:0] : cur_byte[VALUE_W-1:NIBBLE_W];
         ev.enable      = !nib_ff[0];
         ev.wait_ms     = (nib_ff == 2'd3) ? cur_trail : WAIT_NIBBLE;
         ev.last        = (nib_ff == 2'd3) && last_byte;
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      byte_in      = byte_ff;
      nib_in       = nib_ff;
      pin_rs_in    = pin_rs_ff;
      pin_nib_in   = pin_nib_ff;
      pin_e_in     = pin_e_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_ev_in    = out_ev_ff;
      unique case (state_ff)
         B_WAIT: begin
            if (job_valid) begin
               job_in   = job;
               byte_in  = '0;
               nib_in   = '0;
               state_in = job.is_init ? B_IDLEV : B_BYTES;
            end
         end
         B_IDLEV: begin
            if (advance) begin
               out_valid_in = 1'b1;
               out_ev_in    = ev;
               state_in     = B_BYTES;
            end
         end
         B_BYTES: begin
            if (advance) begin
               out_valid_in = 1'b1;
               out_ev_in    = ev;
               pin_rs_in    = ev.reg_select;
               pin_nib_in   = ev.data_nibble;
               pin_e_in     = ev.enable;
               nib_in       = nib_ff + 2'd1;
               if (nib_ff == 2'd3) begin
                  if (last_byte) begin
                     state_in = B_WAIT;
                  end else begin
                     byte_in = byte_ff + BYTE_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = B_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_WAIT;
         byte_ff      <= '0;
         nib_ff       <= '0;
         pin_rs_ff    <= 1'b0;
         pin_nib_ff   <= '0;
         pin_e_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_ff      <= byte_in;
         nib_ff       <= nib_in;
         pin_rs_ff    <= pin_rs_in;
         pin_nib_ff   <= pin_nib_in;
         pin_e_ff     <= pin_e_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff    <= job_in;
      out_ev_ff <= out_ev_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.reg_select  = out_ev_ff.reg_select;
   assign rsp_ch.read_write  = out_ev_ff.read_write;
   assign rsp_ch.data_nibble = out_ev_ff.data_nibble;
   assign rsp_ch.enable      = out_ev_ff.enable;
   assign rsp_ch.wait_ms     = out_ev_ff.wait_ms;
   assign rsp_ch.last        = out_ev_ff.last;

endmodule

`default_nettype wire

[rtl/char_lcd_nibble_write_sequencer_unit.sv]
// Top level of the character LCD nibble write sequencer.
// Depends on clcd_pkg, clcd_if, clcd_front, clcd_queue and clcd_back.
//
//   Channel   Direction  Beat carries
//   req_ch    in         op, value, row, column, number, starts_text
//   rsp_ch    out        reg_select, read_write, data_nibble, enable, wait_ms, last
//
// An integer request is converted digit by digit (up to ten decimal digits) in
// the front end's divide-by-ten step before its job enters the two-entry queue.
// The back end picks up a job and then emits one pin event per cycle unless
// rsp_ch.ready stalls it, four per byte, so an integer of ten digits gives 44
// events. Reset is synchronous and clears all control state and the remembered
// pin levels. Requests stall while a conversion runs or the queue is full;
// events stall only on rsp_ch.ready, held in the output register.
`default_nettype none

module char_lcd_nibble_write_sequencer_unit (
   input wire logic clock,
   input wire logic reset,
   clcd_req_if.sink   req_ch,
   clcd_rsp_if.source rsp_ch
);
   import clcd_pkg::*;

   // Jobs flow front -> queue -> back.
   logic         push_valid;
   clcd_job_type push_job;
   logic         queue_full;
   logic         job_valid;
   clcd_job_type job;
   logic         job_pop;

   // The front end classifies each beat and expands integers into digits.
   clcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // The queue lets the front end take the next request while events drain.
   clcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (job_valid),
      .pop_job    (job),
      .pop_ready  (job_pop)
   );

   // The back end sequences the pins and keeps the last levels for the idle
   // event that opens an init.
   clcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

[rtl/clcd_checker.sv]
// Port-level checks for the character LCD sequencer, bound to the top level.
// Depends on clcd_pkg for field widths.
`default_nettype none

module clcd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_reg_select,
   input wire logic                          rsp_read_write,
   input wire logic [clcd_pkg::NIBBLE_W-1:0] rsp_data_nibble,
   input wire logic                          rsp_enable,
   input wire logic [clcd_pkg::WAIT_W-1:0]   rsp_wait_ms,
   input wire logic                          rsp_last
);
   import clcd_pkg::*;

   a_write_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_read_write)
      else $error("read_write pin driven high");

   a_strobe_timing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enable |-> (rsp_wait_ms == WAIT_NIBBLE) && !rsp_last)
      else $error("strobe event with wrong hold time or marked last");

   a_wait_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wait_ms == WAIT_NONE) || (rsp_wait_ms == 6'd1) ||
                    (rsp_wait_ms == WAIT_NIBBLE) || (rsp_wait_ms == WAIT_TEXT) ||
                    (rsp_wait_ms == WAIT_INIT_IDLE))
      else $error("unexpected hold time");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_nibble) &&
                                  $stable(rsp_reg_select) && $stable(rsp_last))
      else $error("stalled event changed");

   // Checked on the first edge after reset is released.
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("event shown straight after reset");

endmodule

bind char_lcd_nibble_write_sequencer_unit clcd_checker u_clcd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_reg_select  (rsp_ch.reg_select),
   .rsp_read_write  (rsp_ch.read_write),
   .rsp_data_nibble (rsp_ch.data_nibble),
   .rsp_enable      (rsp_ch.enable),
   .rsp_wait_ms     (rsp_ch.wait_ms),
   .rsp_last        (rsp_ch.last)
);

`default_nettype wire

[tb/char_lcd_nibble_write_sequencer_unit_tb.sv]
// Testbench for the character LCD nibble write sequencer.
// Drives requests and checks every pin event against a predictor of its own.
// Depends on clcd_pkg, clcd_if and the RTL of char_lcd_nibble_write_sequencer_unit.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_unit_tb;
   import clcd_pkg::*;

   // Op codes that the block does not define: such a request is dropped silently.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   // Power-up command bytes of the display and the trailing hold after each one.
   localparam logic [VALUE_W-1:0] POWER_UP_CMDS [INIT_BYTES] =
      '{8'h02, 8'h2C, 8'h0C, 8'h01, 8'h06};
   localparam logic [WAIT_W-1:0] POWER_UP_HOLDS [INIT_BYTES] =
      '{6'd0, 6'd1, 6'd1, 6'd2, 6'd0};

   // Cycles without any accepted beat on either channel before the run is abandoned.
   // The longest legitimate quiet stretch is the deliberate receiver hold-off.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 400;
   // Room after the last expected event for a job to be picked up and a long
   // integer to be converted, so this comfortably covers any straggling beat.
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS = 100;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [VALUE_W-1:0]  value;
      logic                row;
      logic [COLUMN_W-1:0] column;
      logic [NUMBER_W-1:0] number;
      logic                starts_text;
   } lcd_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clcd_req_if req_ch ();
   clcd_rsp_if rsp_ch ();

   char_lcd_nibble_write_sequencer_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Pin levels after the most recent event; the idle event of a power-up
   // sequence repeats them. Read/write is never driven high, so it is not kept.
   logic                pin_rs     = 1'b0;
   logic [NIBBLE_W-1:0] pin_nibble = '0;
   logic                pin_enable = 1'b0;

   clcd_event_type pin_burst[$];        // events of the request being expanded
   clcd_event_type expected_events[$];  // events still owed by the block

   int mismatch_count = 0;
   int events_checked = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_asked = 0;    // long hold-offs asked for by the tests
   int hold_taken = 0;    // long hold-offs the receiver has started
   int hold_left = 0;
   int quiet_cycles = 0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void add_pin_event(input logic rs, input logic [NIBBLE_W-1:0] nibble,
                                         input logic en, input logic [WAIT_W-1:0] hold);
      clcd_event_type ev;
      ev.reg_select  = rs;
      ev.read_write  = 1'b0;
      ev.data_nibble = nibble;
      ev.enable      = en;
      ev.wait_ms     = hold;
      ev.last        = 1'b0;
      pin_burst.push_back(ev);
      pin_rs     = rs;
      pin_nibble = nibble;
      pin_enable = en;
   endfunction

   // A byte is strobed out high nibble first, each nibble with E raised then dropped.
   function automatic void add_byte(input logic rs, input logic [VALUE_W-1:0] b,
                                    input logic [WAIT_W-1:0] trail);
      add_pin_event(rs, b[7:4], 1'b1, WAIT_NIBBLE);
      add_pin_event(rs, b[7:4], 1'b0, WAIT_NIBBLE);
      add_pin_event(rs, b[3:0], 1'b1, WAIT_NIBBLE);
      add_pin_event(rs, b[3:0], 1'b0, trail);
   endfunction

   // A column above 39 is ORed in as it stands; its bits stay below the
   // second-line bit.
   function automatic void add_position(input logic row, input logic [COLUMN_W-1:0] column);
      logic [VALUE_W-1:0] addr;
      addr = POS_CMD | (row ? ROW1_BIT : 8'h00) | {2'b00, column};
      add_byte(1'b0, addr, WAIT_NONE);
   endfunction

   function automatic void expand_request(input lcd_request_type r);
      clcd_event_type      ev;
      logic [NIBBLE_W-1:0] digit [MAX_DIGITS];
      logic [NUMBER_W-1:0] rest;
      int                  count;
      pin_burst.delete();
      case (r.op)
         OP_INIT: begin
            ev.reg_select  = pin_rs;
            ev.read_write  = 1'b0;
            ev.data_nibble = pin_nibble;
            ev.enable      = pin_enable;
            ev.wait_ms     = WAIT_INIT_IDLE;
            ev.last        = 1'b0;
            pin_burst.push_back(ev);
            for (int i = 0; i < INIT_BYTES; i++) begin
               add_byte(1'b0, POWER_UP_CMDS[i], POWER_UP_HOLDS[i]);
            end
         end
         OP_COMMAND: add_byte(1'b0, r.value, WAIT_NONE);
         OP_DATA:    add_byte(1'b1, r.value, WAIT_NONE);
         OP_TEXT: begin
            if (r.starts_text) begin
               add_position(r.row, r.column);
            end
            add_byte(1'b1, r.value, WAIT_TEXT);
         end
         OP_SETPOS: add_position(r.row, r.column);
         OP_INTEGER: begin
            // Least significant digit first; zero still yields a single digit.
            rest  = r.number;
            count = 0;
            do begin
               digit[count] = NIBBLE_W'(rest % 10);
               rest         = rest / 10;
               count++;
            end while (rest != 0 && count < MAX_DIGITS);
            add_position(r.row, r.column);
            for (int i = count - 1; i >= 0; i--) begin
               add_byte(1'b1, CHAR_ZERO + {4'h0, digit[i]}, WAIT_TEXT);
            end
         end
         default: return;
      endcase
      ev = pin_burst.pop_back();
      ev.last = 1'b1;
      pin_burst.push_back(ev);
      foreach (pin_burst[i]) begin
         expected_events.push_back(pin_burst[i]);
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < MAX_REPORTS) begin
         $display("%0t: mismatch at event %0d: %s got %0d expected %0d",
                  $realtime, events_checked, what, got, want);
      end
      mismatch_count++;
   endtask

   // Outputs and the receiver's ready are sampled as they stood before the edge.
   // An event beat is checked before the request beat of the same edge is
   // expanded, since a request cannot produce an event on the edge that takes it.
   always @(posedge clock) begin
      clcd_event_type  want;
      lcd_request_type taken;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch("event beat with nothing expected, nibble",
                               rsp_ch.data_nibble, 0);
            end else begin
               want = expected_events.pop_front();
               if (rsp_ch.reg_select !== want.reg_select)
                  report_mismatch("reg_select", rsp_ch.reg_select, want.reg_select);
               if (rsp_ch.read_write !== want.read_write)
                  report_mismatch("read_write", rsp_ch.read_write, want.read_write);
               if (rsp_ch.data_nibble !== want.data_nibble)
                  report_mismatch("data_nibble", rsp_ch.data_nibble, want.data_nibble);
               if (rsp_ch.enable !== want.enable)
                  report_mismatch("enable", rsp_ch.enable, want.enable);
               if (rsp_ch.wait_ms !== want.wait_ms)
                  report_mismatch("wait_ms", rsp_ch.wait_ms, want.wait_ms);
               if (rsp_ch.last !== want.last)
                  report_mismatch("last", rsp_ch.last, want.last);
            end
            events_checked++;
         end
         if (req_ch.valid && req_ch.ready) begin
            taken.op          = req_ch.op;
            taken.value       = req_ch.value;
            taken.row         = req_ch.row;
            taken.column      = req_ch.column;
            taken.number      = req_ch.number;
            taken.starts_text = req_ch.starts_text;
            expand_request(taken);
         end
      end
   end

   // The watchdog counts edges at which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: stalls at random at the phase's rate, and holds off entirely while
   // a long hold-off is counting down. A test asks for a hold-off by raising
   // hold_asked; this process alone loads and counts down hold_left.
   always @(posedge clock) begin
      if (hold_taken != hold_asked) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= LONG_HOLD_CYCLES;
         hold_taken   <= hold_asked;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Offers one request and returns on the edge that accepts it, leaving valid
   // high so that a back-to-back request keeps the channel busy.
   task automatic send_request(input lcd_request_type r);
      int gap;
      gap = 0;
      while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= r.op;
      req_ch.value       <= r.value;
      req_ch.row         <= r.row;
      req_ch.column      <= r.column;
      req_ch.number      <= r.number;
      req_ch.starts_text <= r.starts_text;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic lcd_request_type make_request(input logic [OP_W-1:0] op,
                                                    input logic [VALUE_W-1:0] value,
                                                    input logic row,
                                                    input logic [COLUMN_W-1:0] column,
                                                    input logic [NUMBER_W-1:0] number,
                                                    input logic starts_text);
      lcd_request_type r;
      r.op          = op;
      r.value       = value;
      r.row         = row;
      r.column      = column;
      r.number      = number;
      r.starts_text = starts_text;
      return r;
   endfunction

   // Integers are spread evenly over their digit count, so short and long
   // conversions both turn up often.
   function automatic logic [NUMBER_W-1:0] random_number();
      int unsigned digits_wanted;
      int unsigned modulus;
      digits_wanted = $urandom_range(MAX_DIGITS, 1);
      if (digits_wanted >= MAX_DIGITS) begin
         return $urandom;
      end
      modulus = 1;
      repeat (digits_wanted) modulus = modulus * 10;
      return $urandom % modulus;
   endfunction

   // Mostly well-formed requests with random contents; a few spare op codes and
   // off-screen columns are mixed in as noise. Unused fields are always random.
   function automatic lcd_request_type random_request();
      lcd_request_type r;
      int unsigned     pick;
      pick          = $urandom_range(99, 0);
      r.value       = VALUE_W'($urandom_range(255, 0));
      r.row         = 1'($urandom_range(1, 0));
      r.column      = ($urandom_range(99, 0) < 85) ? COLUMN_W'($urandom_range(39, 0))
                                                  : COLUMN_W'($urandom_range(63, 40));
      r.number      = random_number();
      r.starts_text = 1'($urandom_range(1, 0));
      if (pick < 5)       r.op = OP_INIT;
      else if (pick < 20) r.op = OP_COMMAND;
      else if (pick < 35) r.op = OP_DATA;
      else if (pick < 60) r.op = OP_TEXT;
      else if (pick < 70) r.op = OP_SETPOS;
      else if (pick < 95) r.op = OP_INTEGER;
      else                r.op = $urandom_range(1, 0) ? OP_SPARE_LO : OP_SPARE_HI;
      return r;
   endfunction

   // Every op, the byte and column extremes, columns above 39 that stay below
   // the second-line bit, zero and the largest integer, the dropped op codes, and
   // a power-up sequence both straight after reset and after other traffic.
   task automatic test_directed_requests();
      send_request(make_request(OP_INIT,     8'h00, 1'b0, 6'd0,  32'd0, 1'b0));
      send_request(make_request(OP_COMMAND,  8'h00, 1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1));
      send_request(make_request(OP_COMMAND,  8'hFF, 1'b0, 6'd0,  32'd0, 1'b0));
      send_request(make_request(OP_DATA,     8'h00, 1'b0, 6'd0,  32'd0, 1'b0));
      send_request(make_request(OP_DATA,     8'hFF, 1'b1, 6'd39, 32'd5, 1'b1));
      send_request(make_request(OP_DATA,     8'hA5, 1'b0, 6'd21, 32'd9, 1'b0));
      send_request(make_request(OP_TEXT,     8'h41, 1'b0, 6'd3,  32'd0, 1'b0));
      send_request(make_request(OP_TEXT,     8'h7A, 1'b1, 6'd39, 32'd0, 1'b1));
      send_request(make_request(OP_TEXT,     8'h5A, 1'b0, 6'd63, 32'd0, 1'b1));
      send_request(make_request(OP_SETPOS,   8'h00, 1'b0, 6'd0,  32'd0, 1'b0));
      send_request(make_request(OP_SETPOS,   8'hFF, 1'b1, 6'd39, 32'd0, 1'b1));
      send_request(make_request(OP_SETPOS,   8'h00, 1'b0, 6'd63, 32'd0, 1'b0));
      send_request(make_request(OP_SETPOS,   8'h00, 1'b1, 6'd40, 32'd0, 1'b0));
      send_request(make_request(OP_INTEGER,  8'h00, 1'b0, 6'd0,  32'd0, 1'b0));
      send_request(make_request(OP_INTEGER,  8'hFF, 1'b1, 6'd39, 32'hFFFF_FFFF, 1'b1));
      send_request(make_request(OP_INTEGER,  8'h00, 1'b0, 6'd10, 32'd1_000_000_000, 1'b0));
      send_request(make_request(OP_INTEGER,  8'h00, 1'b1, 6'd5,  32'd7, 1'b0));
      send_request(make_request(OP_INTEGER,  8'h00, 1'b0, 6'd63, 32'd10, 1'b0));
      send_request(make_request(OP_SPARE_LO, 8'hFF, 1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1));
      send_request(make_request(OP_SPARE_HI, 8'h00, 1'b0, 6'd0,  32'd0, 1'b0));
      send_request(make_request(OP_INIT,     8'hFF, 1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1));
      send_request(make_request(OP_DATA,     8'h3C, 1'b0, 6'd0,  32'd0, 1'b0));
      send_request(make_request(OP_INIT,     8'h00, 1'b0, 6'd0,  32'd0, 1'b0));
   endtask

   // The receiver holds off for a long stretch while long integers keep coming,
   // so the queue fills and the request channel must stall.
   task automatic test_event_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_asked <= hold_asked + 1;
      for (int i = 0; i < 32; i++) begin
         send_request(make_request(OP_INTEGER, VALUE_W'($urandom_range(255, 0)),
                                   1'($urandom_range(1, 0)),
                                   COLUMN_W'($urandom_range(39, 0)), $urandom,
                                   1'($urandom_range(1, 0))));
      end
   endtask

   task automatic test_random_requests(input int count, input int idle_pct,
                                       input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         send_request(random_request());
      end
   endtask

   // Drops valid, lets the block run dry and leaves room for any stray beat.
   task automatic wait_for_drain();
      req_ch.valid       <= 1'b0;
      receiver_stall_pct = 0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.op          = OP_INIT;
      req_ch.value       = '0;
      req_ch.row         = 1'b0;
      req_ch.column      = '0;
      req_ch.number      = '0;
      req_ch.starts_text = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_requests();
      test_event_backpressure();
      test_random_requests(104, 0, 0);
      test_random_requests(104, 65, 0);
      test_random_requests(104, 0, 65);
      test_random_requests(104, 30, 30);
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/clcd_pkg.sv
rtl/clcd_if.sv
rtl/clcd_front.sv
rtl/clcd_queue.sv
rtl/clcd_back.sv
rtl/char_lcd_nibble_write_sequencer_unit.sv
rtl/clcd_checker.sv
tb/char_lcd_nibble_write_sequencer_unit_tb.sv
